/* rtl/core/bpskm_pkg.sv */
package bpskm_pkg;

  // Register indexes on the configuration channel.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE_SCALE = 8'd1;

  localparam int unsigned STEP_W = 32;
  localparam int unsigned AMP_W  = 15;
  localparam int unsigned ANGLE_W = 32;

  localparam logic [STEP_W-1:0] PHASE_STEP_RESET      = 32'h4000_0000;
  localparam logic [AMP_W-1:0]  AMPLITUDE_SCALE_RESET = 15'd32767;

  // CORDIC gain 0.6072529350 in Q31.
  localparam int unsigned GAIN_W = 31;
  localparam logic [GAIN_W-1:0] GAIN_Q31 = 31'd1304065748;

  // Fraction bits kept below the output LSB.
  localparam int unsigned GUARD_BITS = 14;

  // Longest CORDIC chain the angle table supports.
  localparam int unsigned TABLE_LEN = 24;

  // Quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Control travelling alongside each sample through the rotator.
  typedef struct packed {
    logic       valid;
    logic [1:0] quad;
  } ctl_t;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32.
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANGLE_W-1:0] t;
    case (idx)
      5'd0:  t = 32'h2000_0000;
      5'd1:  t = 32'h12E4_051E;
      5'd2:  t = 32'h09FB_385B;
      5'd3:  t = 32'h0511_11D4;
      5'd4:  t = 32'h028B_0D43;
      5'd5:  t = 32'h0145_D7E1;
      5'd6:  t = 32'h00A2_F61E;
      5'd7:  t = 32'h0051_7C55;
      5'd8:  t = 32'h0028_BE53;
      5'd9:  t = 32'h0014_5F2F;
      5'd10: t = 32'h000A_2F98;
      5'd11: t = 32'h0005_17CC;
      5'd12: t = 32'h0002_8BE6;
      5'd13: t = 32'h0001_45F3;
      5'd14: t = 32'h0000_A2FA;
      5'd15: t = 32'h0000_517D;
      5'd16: t = 32'h0000_28BE;
      5'd17: t = 32'h0000_145F;
      5'd18: t = 32'h0000_0A30;
      5'd19: t = 32'h0000_0518;
      5'd20: t = 32'h0000_028C;
      5'd21: t = 32'h0000_0146;
      5'd22: t = 32'h0000_00A3;
      5'd23: t = 32'h0000_0051;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/core/bpsk_complex_modulator.sv */
// BPSK modulator built on a complex numerically controlled oscillator.
// Each request on the input stream carries one data bit in in_tdata[0]; the
// block answers it with exactly one complex sample on the output stream,
// I in the low SAMPLE_BITS of out_tdata and Q directly above it. A data bit
// of one adds half a turn to the carrier phase of that sample.
// The configuration channel writes the phase step (index 0) and the
// amplitude scale (index 1); cfg_ready is always high and writes to any
// other index are dropped. Registers are meant to be written while the
// block is empty.
// The whole datapath advances together: one phase stage, one cell per
// CORDIC iteration (CORDIC_STAGES, capped at 24) and an output register.
// A request moves from the phase stage through the cells to the output
// register; one request is taken every cycle while the output flows.
// When the receiver holds out_tready low with a sample waiting, the chain
// freezes and in_tready falls in the same cycle; nothing is lost or repeated.
// Synchronous reset clears the phase accumulator to zero, restores the
// register defaults and empties the chain.
module bpsk_complex_modulator #(
  parameter int PHASE_BITS    = 32,
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream: in_tdata = {7'b0, data_bit}.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,
  // Output stream: out_tdata fields from bit 0 up are i_sample, q_sample,
  // then zero fill to a whole byte.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bpskm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bpskm_pkg::STEP_W-1:0]          cfg_data
);

  localparam int NS      = (CORDIC_STAGES > bpskm_pkg::TABLE_LEN) ?
                           bpskm_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int FRAC    = SAMPLE_BITS - 1 + bpskm_pkg::GUARD_BITS;
  localparam int XW      = FRAC + 3;
  localparam int PROD_W  = bpskm_pkg::AMP_W + bpskm_pkg::GAIN_W;
  localparam int OUT_W   = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int RW      = XW - bpskm_pkg::GUARD_BITS + 1;
  localparam int AW      = bpskm_pkg::ANGLE_W;

  localparam logic signed [XW:0]   ROUND_BIAS = (XW+1)'(1 << (bpskm_pkg::GUARD_BITS - 1));
  localparam logic signed [RW-1:0] SAT_MAX    = RW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_MIN    = RW'(-(1 << (SAMPLE_BITS - 1)));

  // Configuration registers.
  logic [bpskm_pkg::STEP_W-1:0] phase_step_r;
  logic [bpskm_pkg::AMP_W-1:0]  amplitude_scale_r;

  // Phase accumulator.
  logic [PHASE_BITS-1:0] acc_r;

  // Chain control: the whole pipeline moves when the output slot is free.
  logic en;
  logic in_fire;

  // Front stage (angle reduction and start vector).
  logic [AW-1:0]          angle;
  logic [AW-1:0]          angle_bias;
  logic [1:0]             quad;
  logic [AW-1:0]          resid;
  logic [PROD_W-1:0]      prod;
  bpskm_pkg::ctl_t        front_ctl_r;
  logic signed [XW-1:0]   front_x_r;
  logic signed [AW-1:0]   front_z_r;

  // Stage data between cells; index k is the input of cell k.
  bpskm_pkg::ctl_t        ctl_s [0:NS];
  logic signed [XW-1:0]   x_s   [0:NS];
  logic signed [XW-1:0]   y_s   [0:NS];
  logic signed [AW-1:0]   z_s   [0:NS];

  // Output stage.
  logic signed [XW-1:0]       rot_i, rot_q;
  logic                       out_valid_r;
  logic [SAMPLE_BITS-1:0]     i_sample_r, q_sample_r;

  // Rounds away the guard bits and saturates to the sample range.
  function automatic logic [SAMPLE_BITS-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [XW:0]   sum;
    logic signed [RW-1:0] r;
    sum = $signed({v[XW-1], v}) + ROUND_BIAS;
    r   = sum[XW:bpskm_pkg::GUARD_BITS];
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_fire   = in_tvalid && in_tready;

  // Register writes; an unknown index leaves everything untouched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r      <= bpskm_pkg::PHASE_STEP_RESET;
      amplitude_scale_r <= bpskm_pkg::AMPLITUDE_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpskm_pkg::REG_PHASE_STEP:      phase_step_r      <= cfg_data;
        bpskm_pkg::REG_AMPLITUDE_SCALE: amplitude_scale_r <= cfg_data[bpskm_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // The accumulator advances once per accepted request and wraps naturally.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (in_fire) begin
      acc_r <= acc_r + PHASE_BITS'(phase_step_r);
    end
  end

  // The oscillator phase as a 32-bit fraction of a turn.
  generate
    if (PHASE_BITS >= AW) begin : g_angle_top
      assign angle = acc_r[PHASE_BITS-1 -: AW] ^ {in_tdata[0], {(AW-1){1'b0}}};
    end else begin : g_angle_pad
      assign angle = {acc_r, {(AW-PHASE_BITS){1'b0}}} ^ {in_tdata[0], {(AW-1){1'b0}}};
    end
  endgenerate

  // Nearest quarter turn and the residual angle within an eighth of a turn.
  always_comb begin
    angle_bias = angle + AW'(32'h2000_0000);
    quad       = angle_bias[AW-1 -: 2];
    resid      = angle - {quad, {(AW-2){1'b0}}};
    prod       = PROD_W'(amplitude_scale_r) * PROD_W'(bpskm_pkg::GAIN_Q31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_ctl_r <= '0;
    end else if (en) begin
      front_ctl_r.valid <= in_tvalid;
      front_ctl_r.quad  <= quad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // The start vector is the amplitude pre-scaled by the CORDIC gain.
      front_x_r <= $signed(XW'(prod[PROD_W-1:PROD_W-FRAC]));
      front_z_r <= $signed(resid);
    end
  end

  assign ctl_s[0] = front_ctl_r;
  assign x_s[0]   = front_x_r;
  assign y_s[0]   = '0;
  assign z_s[0]   = front_z_r;

  generate
    for (genvar k = 0; k < NS; k++) begin : g_cell
      bpskm_cordic_cell #(
        .IDX (k),
        .XW  (XW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_s[k]),
        .x_in    (x_s[k]),
        .y_in    (y_s[k]),
        .z_in    (z_s[k]),
        .ctl_out (ctl_s[k+1]),
        .x_out   (x_s[k+1]),
        .y_out   (y_s[k+1]),
        .z_out   (z_s[k+1])
      );
    end
  endgenerate

  // Put the quarter turn back by swapping and negating the rotated vector.
  always_comb begin
    case (ctl_s[NS].quad)
      bpskm_pkg::QUAD_1: begin
        rot_i = -y_s[NS];
        rot_q = x_s[NS];
      end
      bpskm_pkg::QUAD_2: begin
        rot_i = -x_s[NS];
        rot_q = -y_s[NS];
      end
      bpskm_pkg::QUAD_3: begin
        rot_i = y_s[NS];
        rot_q = -x_s[NS];
      end
      default: begin
        rot_i = x_s[NS];
        rot_q = y_s[NS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_s[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_sample_r <= finish(rot_i);
      q_sample_r <= finish(rot_q);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({q_sample_r, i_sample_r});

endmodule

/* rtl/core/bpskm_cordic_cell.sv */
// One micro-rotation of the rotation-mode CORDIC, registered.
module bpskm_cordic_cell #(
  parameter int IDX = 0,
  parameter int XW  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  bpskm_pkg::ctl_t                     ctl_in,
  input  logic signed [XW-1:0]                x_in,
  input  logic signed [XW-1:0]                y_in,
  input  logic signed [bpskm_pkg::ANGLE_W-1:0] z_in,
  output bpskm_pkg::ctl_t                     ctl_out,
  output logic signed [XW-1:0]                x_out,
  output logic signed [XW-1:0]                y_out,
  output logic signed [bpskm_pkg::ANGLE_W-1:0] z_out
);

  localparam logic [bpskm_pkg::ANGLE_W-1:0] ANGLE = bpskm_pkg::atan_turn(5'(IDX));

  bpskm_pkg::ctl_t                      ctl_r;
  logic signed [XW-1:0]                 x_r, x_nxt;
  logic signed [XW-1:0]                 y_r, y_nxt;
  logic signed [bpskm_pkg::ANGLE_W-1:0] z_r, z_nxt;
  logic signed [XW-1:0]                 dx, dy;

  always_comb begin
    dx = y_in >>> IDX;
    dy = x_in >>> IDX;
    // Rotate towards zero residual angle; both updates use the old vector.
    if (!z_in[bpskm_pkg::ANGLE_W-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - $signed(ANGLE);
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + $signed(ANGLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

/* test/bpskm_iq_checker.sv */
`timescale 1ns / 1ps

module bpskm_iq_checker #(
  parameter int PHASE_BITS    = 32,
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int OUT_W         = ((2*SAMPLE_BITS+7)/8)*8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bpskm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpskm_pkg::STEP_W-1:0]      cfg_data,
  output int                                errors,
  output int                                pending
);

  localparam int FRAC   = SAMPLE_BITS - 1 + bpskm_pkg::GUARD_BITS;
  localparam int PASSES = (CORDIC_STAGES > bpskm_pkg::TABLE_LEN) ?
                          bpskm_pkg::TABLE_LEN : CORDIC_STAGES;

  // Rotation angle of each CORDIC pass, in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN [0:23] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] i_val;
    logic signed [SAMPLE_BITS-1:0] q_val;
  } iq_t;

  iq_t                            iq_due[$];
  logic [PHASE_BITS-1:0]          phase_acc;
  logic [bpskm_pkg::STEP_W-1:0]   phase_inc;
  logic [bpskm_pkg::AMP_W-1:0]    amp_scale;
  int                             mismatches = 0;
  int                             samples_seen = 0;
  int                             due_count = 0;

  assign errors  = mismatches;
  assign pending = due_count;

  task automatic report(input string msg);
    mismatches++;
    $display("%0t ns: sample %0d: %s", $time, samples_seen, msg);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input longint v);
    longint lim;
    longint r;
    lim = longint'(1) <<< (SAMPLE_BITS - 1);
    r = (v + (longint'(1) <<< (bpskm_pkg::GUARD_BITS - 1))) >>> bpskm_pkg::GUARD_BITS;
    if (r > lim - 1)
      r = lim - 1;
    else if (r < -lim)
      r = -lim;
    return r[SAMPLE_BITS-1:0];
  endfunction

  function automatic iq_t modulate_bit(input logic [PHASE_BITS-1:0] phase,
                                       input logic bit_in,
                                       input logic [bpskm_pkg::AMP_W-1:0] amp);
    logic [PHASE_BITS+31:0] wide;
    logic [31:0] turn;
    logic [31:0] resid;
    logic [1:0]  quad;
    longint x, y, z, dx, dy, t;
    iq_t r;
    // Align the accumulator to a 32-bit fraction of a turn.
    wide = {phase, 32'b0} >> PHASE_BITS;
    turn = wide[31:0];
    if (bit_in)
      turn[31] = ~turn[31];
    quad  = 2'((turn + 32'h2000_0000) >> 30);
    resid = turn - {quad, 30'b0};
    z = longint'($signed(resid));
    x = longint'((64'(amp) * 64'(bpskm_pkg::GAIN_Q31)) >> (46 - FRAC));
    y = 0;
    for (int k = 0; k < PASSES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURN[k]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURN[k]);
      end
    end
    case (quad)
      bpskm_pkg::QUAD_1: begin
        t = x;
        x = -y;
        y = t;
      end
      bpskm_pkg::QUAD_2: begin
        x = -x;
        y = -y;
      end
      bpskm_pkg::QUAD_3: begin
        t = x;
        x = y;
        y = -t;
      end
      default: ;
    endcase
    r.i_val = round_sat(x);
    r.q_val = round_sat(y);
    return r;
  endfunction

  always @(posedge clk) begin
    iq_t got;
    iq_t want;
    if (!rst_n) begin
      phase_acc = '0;
      phase_inc = bpskm_pkg::PHASE_STEP_RESET;
      amp_scale = bpskm_pkg::AMPLITUDE_SCALE_RESET;
      iq_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpskm_pkg::REG_PHASE_STEP:      phase_inc = cfg_data;
          bpskm_pkg::REG_AMPLITUDE_SCALE: amp_scale = cfg_data[bpskm_pkg::AMP_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.i_val = out_tdata[SAMPLE_BITS-1:0];
        got.q_val = out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (iq_due.size() == 0) begin
          report($sformatf("unexpected sample I=%0d Q=%0d", got.i_val, got.q_val));
        end else begin
          want = iq_due.pop_front();
          if (got.i_val !== want.i_val)
            report($sformatf("I is %0d, should be %0d", got.i_val, want.i_val));
          if (got.q_val !== want.q_val)
            report($sformatf("Q is %0d, should be %0d", got.q_val, want.q_val));
        end
        samples_seen++;
      end
      if (in_tvalid && in_tready) begin
        iq_due.push_back(modulate_bit(phase_acc, in_tdata[0], amp_scale));
        phase_acc = phase_acc + PHASE_BITS'(phase_inc);
      end
    end
    due_count = iq_due.size();
  end

endmodule

/* test/tb_bpsk_complex_modulator.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the BPSK modulator. The checker instantiated
// beside the block watches all three channels, predicts every sample and
// counts mismatches; this module drives the channels and decides the end.
module tb_bpsk_complex_modulator;

  localparam int PHASE_BITS    = 32;
  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int OUT_W         = ((2*SAMPLE_BITS+7)/8)*8;

  // Cycles without any accepted request before the run is declared hung.
  // A correct run never comes near this: the longest quiet stretch is the
  // pause before a register write plus one pipeline drain.
  localparam int STUCK_LIMIT = 2000;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 212;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [7:0]                        in_tdata;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [OUT_W-1:0]                  out_tdata;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [bpskm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bpskm_pkg::STEP_W-1:0]      cfg_data;

  int errors;
  int pending;
  int stuck_cycles = 0;
  int stall_left = 0;
  // When set, neither side inserts idle cycles.
  logic quiet = 1'b1;

  always #10 clk = ~clk;

  bpsk_complex_modulator #(
    .PHASE_BITS   (PHASE_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bpskm_iq_checker #(
    .PHASE_BITS   (PHASE_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .OUT_W        (OUT_W)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // The receiver now and then stalls, counting each burst down in stall_left.
  // Everything changes on the falling edge so that the block sees settled
  // values at the rising edge.
  always @(negedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // The watchdog restarts whenever any channel completes a request.
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_valid && cfg_ready)))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one input request and returns once the block has taken it.
  // Bit 0 is the data bit; the upper bits are padding that must be ignored.
  task automatic send_bit(input logic [7:0] word);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // Occasionally leaves the input channel empty for a burst of cycles.
  // Junk is placed on the data lines meanwhile, since it must not matter.
  task automatic maybe_pause();
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // A random request word: the data bit, and now and then noise above it.
  function automatic logic [7:0] random_word();
    logic [7:0] word;
    word = {7'b0, 1'($urandom_range(0, 1))};
    if ($urandom_range(0, 3) == 0)
      word[7:1] = 7'($urandom);
    return word;
  endfunction

  // Registers are only written with the chain empty. Once the last expected
  // sample has come out, the task waits further, long enough for the whole
  // pipeline to empty, before the write.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (CORDIC_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpskm_pkg::CFG_INDEX_W-1:0] index,
                           input logic [bpskm_pkg::STEP_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Picks a carrier step, favouring the extremes and powers of two, which
  // land the phase exactly on quadrant and octant boundaries.
  function automatic logic [bpskm_pkg::STEP_W-1:0] random_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return bpskm_pkg::STEP_W'(1) << $urandom_range(0, bpskm_pkg::STEP_W - 1);
      3:       return bpskm_pkg::STEP_W'($urandom_range(1, 1000));
      default: return bpskm_pkg::STEP_W'($urandom);
    endcase
  endfunction

  // Picks an amplitude word. Bits above the register's width are often set
  // so that truncation of wide writes is exercised as well.
  function automatic logic [bpskm_pkg::STEP_W-1:0] random_amp();
    logic [bpskm_pkg::STEP_W-1:0] value;
    value = bpskm_pkg::STEP_W'($urandom);
    case ($urandom_range(0, 4))
      0:       value[bpskm_pkg::AMP_W-1:0] = '0;
      1:       value[bpskm_pkg::AMP_W-1:0] = '1;
      2:       value[bpskm_pkg::AMP_W-1:0] = bpskm_pkg::AMP_W'($urandom_range(32000, 32767));
      default: ;
    endcase
    return value;
  endfunction

  task automatic random_config();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(bpskm_pkg::REG_PHASE_STEP, random_step());
      write_reg(bpskm_pkg::REG_AMPLITUDE_SCALE, random_amp());
    end else begin
      write_reg(bpskm_pkg::REG_AMPLITUDE_SCALE, random_amp());
      write_reg(bpskm_pkg::REG_PHASE_STEP, random_step());
    end
    // A write to an unused index must leave both registers alone.
    if ($urandom_range(0, 2) == 0)
      write_reg(bpskm_pkg::CFG_INDEX_W'($urandom_range(2, 255)),
                bpskm_pkg::STEP_W'($urandom));
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the reset values: a quarter turn per sample
    // at full scale, so both data bits meet every quadrant. The upper bits
    // of some words carry noise that the block must ignore.
    send_bit(8'h00);
    send_bit(8'h01);
    send_bit(8'hFE);
    send_bit(8'hFF);
    send_bit(8'h01);
    send_bit(8'h00);
    send_bit(8'h81);
    send_bit(8'h7E);
    drain();

    // An eighth of a turn per step puts every other sample exactly on a
    // boundary between quadrants, where the residual angle is at its most
    // negative.
    write_reg(bpskm_pkg::REG_PHASE_STEP, 32'h2000_0000);
    write_reg(bpskm_pkg::REG_AMPLITUDE_SCALE, 32'h0000_7FFF);
    for (int n = 0; n < 8; n++)
      send_bit({7'b0, 1'(n / 4)});
    drain();

    // Largest step with zero amplitude; writes to unused indexes in between.
    write_reg(bpskm_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(bpskm_pkg::CFG_INDEX_W'(2), 32'h1234_5678);
    write_reg(bpskm_pkg::REG_AMPLITUDE_SCALE, 32'h0000_0000);
    write_reg(bpskm_pkg::CFG_INDEX_W'(255), 32'hFFFF_FFFF);
    send_bit(8'h00);
    send_bit(8'h01);
    send_bit(8'h00);
    drain();

    // A zero step freezes the phase; the amplitude write carries bits above
    // the register, leaving an amplitude of one.
    write_reg(bpskm_pkg::REG_PHASE_STEP, 32'h0000_0000);
    write_reg(bpskm_pkg::REG_AMPLITUDE_SCALE, 32'hFFFF_8001);
    send_bit(8'h01);
    send_bit(8'h00);
    send_bit(8'h01);
    drain();

    // Random part: a fresh setting in each phase, idling on most of them and
    // none at all in the last one.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      quiet = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_bit(random_word());
        maybe_pause();
      end
      drain();
    end

    // The last drain already waited for the final sample and then long enough
    // for the pipeline to empty, so any stray output has shown by now.
    if (errors == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/bpskm_pkg.sv
rtl/core/bpskm_cordic_cell.sv
rtl/core/bpsk_complex_modulator.sv
test/bpskm_iq_checker.sv
test/tb_bpsk_complex_modulator.sv
